### rtl/rsst_pkg.sv
// Shared types and codes for the range-sum segment tree block.
// No dependencies; the files that use it refer to this package by scoped names.
`timescale 1ns / 1ps

package rsst_pkg;

  localparam logic CMD_SET   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  localparam int unsigned COUNT_W = 11;
  localparam int unsigned INDEX_W = 10;
  localparam int unsigned VALUE_W = 32;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

  typedef struct packed {
    logic                       command;
    logic [INDEX_W-1:0]         element_index;
    logic signed [VALUE_W-1:0]  new_value;
    logic [INDEX_W-1:0]         range_start;
    logic [INDEX_W-1:0]         range_end;
  } item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] range_sum;
    logic                      status;
  } result_t;

endpackage

### rtl/rsst_in_if.sv
// Request channel: valid/ready handshake carrying one set or query beat.
// Depends on rsst_pkg for field widths.
`timescale 1ns / 1ps

interface rsst_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   command;
  logic [rsst_pkg::INDEX_W-1:0]           element_index;
  logic signed [rsst_pkg::VALUE_W-1:0]    new_value;
  logic [rsst_pkg::INDEX_W-1:0]           range_start;
  logic [rsst_pkg::INDEX_W-1:0]           range_end;

  modport source (output valid, command, element_index, new_value, range_start, range_end,
                  input ready);
  modport sink (input valid, command, element_index, new_value, range_start, range_end,
                output ready);
endinterface

### rtl/rsst_out_if.sv
// Response channel: valid/ready handshake carrying one result beat.
// Depends on rsst_pkg for field widths.
`timescale 1ns / 1ps

interface rsst_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [rsst_pkg::VALUE_W-1:0] range_sum;
  logic                                status;

  modport source (output valid, range_sum, status, input ready);
  modport sink (input valid, range_sum, status, output ready);
endinterface

### rtl/range_sum_segment_tree_core.sv
// Top level of the range-sum segment tree: count register, node memory,
// walker and output register. Uses rsst_pkg, rsst_in_if, rsst_out_if,
// rsst_node_ram and rsst_walker.
`timescale 1ns / 1ps

//  Channel    Kind           Carries
//  request    valid/ready    command, element_index, new_value, range_start, range_end
//  response   valid/ready    range_sum, status
//  cfg        write enable   element_count (11 bits)
//
//  A set walks from leaf to root one tree level at a time, as the single read
//  port of the node memory allows. A query takes two walker steps for each
//  of up to log2(LEAVES) + 1 levels, with at most one node read each. Rejected
//  items go straight to the result. After reset every node of the node
//  memory is cleared, and request.ready stays low while that runs. A result
//  waiting in the output register does not stop the next item from being
//  accepted; the walker holds its own result until the register frees.

module range_sum_segment_tree_core #(
  parameter int LEAVES     = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  rsst_in_if.sink                      request,
  rsst_out_if.source                   response,
  input  logic                         cfg_we,
  input  logic [rsst_pkg::COUNT_W-1:0] cfg_wdata
);

  localparam int NW = $clog2(2*LEAVES);

  logic [rsst_pkg::COUNT_W-1:0] element_count;
  rsst_pkg::item_t              item;
  rsst_pkg::result_t            res;
  logic                         res_valid;
  logic                         res_ready;
  logic                         ram_we;
  logic [NW-1:0]                ram_waddr;
  logic [NW-1:0]                ram_raddr;
  logic [DATA_WIDTH-1:0]        ram_wdata;
  logic [DATA_WIDTH-1:0]        ram_rdata;
  logic                         out_valid;
  rsst_pkg::result_t            out_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= rsst_pkg::COUNT_RESET;
    end else if (cfg_we) begin
      element_count <= cfg_wdata;
    end
  end

  assign item.command       = request.command;
  assign item.element_index = request.element_index;
  assign item.new_value     = request.new_value;
  assign item.range_start   = request.range_start;
  assign item.range_end     = request.range_end;

  rsst_node_ram #(
    .DEPTH (2*LEAVES),
    .AW    (NW),
    .DW    (DATA_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rsst_walker #(
    .LEAVES     (LEAVES),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_walker (
    .clk           (clk),
    .rst           (rst),
    .item          (item),
    .item_valid    (request.valid),
    .item_ready    (request.ready),
    .element_count (element_count),
    .res           (res),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata)
  );

  // Output register: free when empty or when its beat is taken this cycle.
  assign res_ready = !out_valid || response.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign response.valid     = out_valid;
  assign response.range_sum = out_res.range_sum;
  assign response.status    = out_res.status;

  // An accepted item keeps the walker busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    request.valid && request.ready |=> !request.ready)
    else $error("request accepted while the previous item was still in progress");

  // A result handed over by the walker shows up on the response channel.
  a_result_registered: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready |=> response.valid)
    else $error("walker result lost at the output register");

  // Rejected items never carry a sum.
  a_error_zero_sum: assert property (@(posedge clk) disable iff (rst)
    response.valid && response.status == rsst_pkg::STATUS_ERR |-> response.range_sum == '0)
    else $error("error result with a nonzero sum");

  // The clearing pass follows reset, so no item is taken right after it.
  a_clear_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> !request.ready)
    else $error("request accepted before the node memory was cleared");

endmodule

### rtl/rsst_node_ram.sv
// Node memory of the sum tree: one write port, one read port, registered read.
// No package dependencies.
`timescale 1ns / 1ps

module rsst_node_ram #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/rsst_walker.sv
// Sequencer that clears the node memory, walks leaf-to-root updates and
// bottom-up range queries, at most one memory read per cycle. Uses rsst_pkg.
`timescale 1ns / 1ps

module rsst_walker #(
  parameter int LEAVES     = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  rsst_pkg::item_t                   item,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  logic [rsst_pkg::COUNT_W-1:0]      element_count,
  output rsst_pkg::result_t                 res,
  output logic                              res_valid,
  input  logic                              res_ready,
  output logic                              ram_we,
  output logic [$clog2(2*LEAVES)-1:0]       ram_waddr,
  output logic [DATA_WIDTH-1:0]             ram_wdata,
  output logic [$clog2(2*LEAVES)-1:0]       ram_raddr,
  input  logic [DATA_WIDTH-1:0]             ram_rdata
);

  localparam int NW = $clog2(2*LEAVES);
  localparam int CW = NW + 1;
  localparam logic [NW-1:0] LAST_NODE = NW'(2*LEAVES - 1);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_DIFF  = 7'b0000100,
    S_UPD   = 7'b0001000,
    S_QL    = 7'b0010000,
    S_QR    = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t                         state, state_next;
  logic [NW-1:0]                  clr_addr, clr_addr_next;
  logic [CW-1:0]                  p, p_next;
  logic [CW-1:0]                  r, r_next;
  logic signed [DATA_WIDTH-1:0]   val, val_next;
  logic signed [DATA_WIDTH-1:0]   diff, diff_next;
  logic signed [DATA_WIDTH-1:0]   sum, sum_next;
  logic                           pending, pending_next;
  logic                           status, status_next;

  logic [CW-1:0]                  p_half;
  logic [CW-1:0]                  r_dec;
  logic [CW-1:0]                  leaf_set, leaf_lo, leaf_hi;
  logic                           set_ok, query_ok;
  logic signed [DATA_WIDTH-1:0]   sum_acc;
  logic signed [DATA_WIDTH-1:0]   rd_val;

  assign rd_val  = $signed(ram_rdata);
  assign p_half  = p >> 1;
  assign r_dec   = r - CW'(1);
  assign sum_acc = pending ? sum + rd_val : sum;

  // Leaf addresses; an index that passes the bounds check is below LEAVES,
  // so the truncation to CW bits is exact.
  assign leaf_set = CW'(32'(LEAVES) + 32'(item.element_index));
  assign leaf_lo  = CW'(32'(LEAVES) + 32'(item.range_start));
  assign leaf_hi  = CW'(32'(LEAVES) + 32'(item.range_end) + 32'd1);

  // The count in use is the register clamped to LEAVES.
  assign set_ok = (32'(item.element_index) < 32'(element_count)) &&
                  (32'(item.element_index) < 32'(LEAVES));
  assign query_ok = (item.range_start <= item.range_end) &&
                    (32'(item.range_end) < 32'(element_count)) &&
                    (32'(item.range_end) < 32'(LEAVES));

  assign res.range_sum = 32'(64'(sum));
  assign res.status    = status;

  always_comb begin
    state_next    = state;
    clr_addr_next = clr_addr;
    p_next        = p;
    r_next        = r;
    val_next      = val;
    diff_next     = diff;
    sum_next      = sum;
    pending_next  = pending;
    status_next   = status;
    item_ready    = 1'b0;
    res_valid     = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_raddr     = '0;

    case (state)
      S_CLEAR: begin
        ram_we        = 1'b1;
        ram_waddr     = clr_addr;
        clr_addr_next = clr_addr + NW'(1);
        if (clr_addr == LAST_NODE) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          val_next     = DATA_WIDTH'(64'(item.new_value));
          sum_next     = '0;
          pending_next = 1'b0;
          status_next  = rsst_pkg::STATUS_OK;
          if (item.command == rsst_pkg::CMD_SET) begin
            if (set_ok) begin
              p_next     = leaf_set;
              ram_raddr  = leaf_set[NW-1:0];
              state_next = S_DIFF;
            end else begin
              status_next = rsst_pkg::STATUS_ERR;
              state_next  = S_DONE;
            end
          end else begin
            if (query_ok) begin
              p_next     = leaf_lo;
              r_next     = leaf_hi;
              state_next = S_QL;
            end else begin
              status_next = rsst_pkg::STATUS_ERR;
              state_next  = S_DONE;
            end
          end
        end
      end

      // The old leaf is on the read port: write the new value and start the
      // walk up with the difference.
      S_DIFF: begin
        diff_next  = val - rd_val;
        ram_we     = 1'b1;
        ram_waddr  = p[NW-1:0];
        ram_wdata  = val;
        p_next     = p_half;
        ram_raddr  = p_half[NW-1:0];
        state_next = S_UPD;
      end

      // Each cycle writes back one ancestor and reads the next one up.
      S_UPD: begin
        ram_we    = 1'b1;
        ram_waddr = p[NW-1:0];
        ram_wdata = rd_val + diff;
        if (p == CW'(1)) begin
          state_next = S_DONE;
        end else begin
          p_next    = p_half;
          ram_raddr = p_half[NW-1:0];
        end
      end

      // Left boundary step; folds in the node read by the previous right step.
      S_QL: begin
        sum_next     = sum_acc;
        pending_next = 1'b0;
        if (p >= r) begin
          state_next = S_DONE;
        end else begin
          if (p[0]) begin
            ram_raddr    = p[NW-1:0];
            pending_next = 1'b1;
            p_next       = p + CW'(1);
          end
          state_next = S_QR;
        end
      end

      // Right boundary step, then both bounds move up one level.
      S_QR: begin
        sum_next     = sum_acc;
        pending_next = 1'b0;
        if (r[0]) begin
          ram_raddr    = r_dec[NW-1:0];
          pending_next = 1'b1;
          r_next       = r_dec >> 1;
        end else begin
          r_next = r >> 1;
        end
        p_next     = p_half;
        state_next = S_QL;
      end

      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      pending  <= 1'b0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      pending  <= pending_next;
    end
    p      <= p_next;
    r      <= r_next;
    val    <= val_next;
    diff   <= diff_next;
    sum    <= sum_next;
    status <= status_next;
  end

endmodule

### sim/rsst_checker.sv
// Checker for the range-sum segment tree: watches the request, response and count port,
// keeps its own sum tree and compares every response beat with the predicted one.
// Depends on rsst_pkg, rsst_in_if and rsst_out_if.
`timescale 1ns / 1ps

module rsst_checker #(
  parameter int LEAVES = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [rsst_pkg::COUNT_W-1:0] cfg_wdata,
  rsst_in_if                           req,
  rsst_out_if                          rsp,
  output int unsigned                  fail_count,
  output int unsigned                  pending
);

  localparam int NW = $clog2(2*LEAVES);

  logic [rsst_pkg::VALUE_W-1:0] node_sum [1:2*LEAVES-1];
  logic [rsst_pkg::COUNT_W-1:0] element_count;
  rsst_pkg::result_t            sums_due[$];
  int unsigned                  mismatches = 0;

  // Updates the tree for a set and returns the response the block owes for the beat.
  function automatic rsst_pkg::result_t apply_command(rsst_pkg::item_t it);
    rsst_pkg::result_t            r;
    int                           limit;
    int                           p;
    int                           lo;
    int                           hi;
    logic [rsst_pkg::VALUE_W-1:0] diff;
    logic [rsst_pkg::VALUE_W-1:0] acc;
    r.range_sum = '0;
    r.status    = rsst_pkg::STATUS_OK;
    acc         = '0;
    limit = (element_count > LEAVES) ? LEAVES : int'(element_count);
    if (it.command == rsst_pkg::CMD_SET) begin
      if (int'(it.element_index) >= limit) begin
        r.status = rsst_pkg::STATUS_ERR;
      end else begin
        p    = LEAVES + int'(it.element_index);
        diff = it.new_value - node_sum[NW'(p)];
        while (p >= 1) begin
          node_sum[NW'(p)] = node_sum[NW'(p)] + diff;
          p = p >> 1;
        end
      end
    end else begin
      if (it.range_start > it.range_end || int'(it.range_end) >= limit) begin
        r.status = rsst_pkg::STATUS_ERR;
      end else begin
        lo = LEAVES + int'(it.range_start);
        hi = LEAVES + int'(it.range_end) + 1;
        // Bottom-up walk over half-open [lo, hi); odd edges are taken whole.
        while (lo < hi) begin
          if (lo % 2 == 1) begin
            acc = acc + node_sum[NW'(lo)];
            lo++;
          end
          if (hi % 2 == 1) begin
            hi--;
            acc = acc + node_sum[NW'(hi)];
          end
          lo = lo >> 1;
          hi = hi >> 1;
        end
        r.range_sum = acc;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    rsst_pkg::result_t got;
    rsst_pkg::result_t want;
    rsst_pkg::item_t   it;
    bit                bad;
    if (rst) begin
      foreach (node_sum[i]) node_sum[i] = '0;
      element_count = rsst_pkg::COUNT_RESET;
      sums_due.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        got.range_sum = rsp.range_sum;
        got.status    = rsp.status;
        if (sums_due.size() == 0) begin
          $display("%0t: response beat with nothing outstanding: sum %h status %b",
                   $time, got.range_sum, got.status);
          mismatches++;
        end else begin
          want = sums_due.pop_front();
          bad  = 1'b0;
          if (got.range_sum !== want.range_sum) begin
            $display("%0t: range_sum mismatch: expected %h actual %h",
                     $time, want.range_sum, got.range_sum);
            bad = 1'b1;
          end
          if (got.status !== want.status) begin
            $display("%0t: status mismatch: expected %b actual %b",
                     $time, want.status, got.status);
            bad = 1'b1;
          end
          if (bad) mismatches++;
        end
      end
      if (req.valid && req.ready) begin
        it.command       = req.command;
        it.element_index = req.element_index;
        it.new_value     = req.new_value;
        it.range_start   = req.range_start;
        it.range_end     = req.range_end;
        sums_due.push_back(apply_command(it));
      end
      if (cfg_we) element_count = cfg_wdata;
    end
    fail_count <= mismatches;
    pending    <= sums_due.size();
  end

endmodule

### sim/tb_top.sv
// Testbench top for range_sum_segment_tree_core: clock, reset, request and count stimulus,
// random response back-pressure and the final verdict. Depends on rsst_pkg, the two channel
// interfaces, the block itself and rsst_checker.
`timescale 1ns / 1ps

module tb_top;

  localparam int IW = rsst_pkg::INDEX_W;
  localparam int CW = rsst_pkg::COUNT_W;

  logic                         clk;
  logic                         rst;
  logic                         cfg_we;
  logic [rsst_pkg::COUNT_W-1:0] cfg_wdata;
  int unsigned                  fail_count;
  int unsigned                  pending;
  bit                           steady;
  int                           count_now;

  rsst_in_if  req ();
  rsst_out_if rsp ();

  range_sum_segment_tree_core dut (
    .clk       (clk),
    .rst       (rst),
    .request   (req),
    .response  (rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  rsst_checker sum_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .req        (req),
    .rsp        (rsp),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int idle_cycles();
    return steady ? 0 : $urandom_range(0, 5);
  endfunction

  // Holds valid high from one beat to the next when no gap is drawn.
  task automatic send_item(rsst_pkg::item_t it);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid         <= 1'b1;
    req.command       <= it.command;
    req.element_index <= it.element_index;
    req.new_value     <= it.new_value;
    req.range_start   <= it.range_start;
    req.range_end     <= it.range_end;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  task automatic send_set(int idx, logic [rsst_pkg::VALUE_W-1:0] val);
    rsst_pkg::item_t it;
    it = '0;
    it.command       = rsst_pkg::CMD_SET;
    it.element_index = IW'(idx);
    it.new_value     = val;
    it.range_start   = IW'($urandom);
    it.range_end     = IW'($urandom);
    send_item(it);
  endtask

  task automatic send_query(int first, int last);
    rsst_pkg::item_t it;
    it = '0;
    it.command       = rsst_pkg::CMD_QUERY;
    it.element_index = IW'($urandom);
    it.new_value     = $urandom;
    it.range_start   = IW'(first);
    it.range_end     = IW'(last);
    send_item(it);
  endtask

  // The pending count is a registered copy of the checker's queue size, hence the first edge.
  task automatic settle();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_count(int value);
    cfg_we    <= 1'b1;
    cfg_wdata <= CW'(value);
    @(posedge clk);
    cfg_we    <= 1'b0;
    count_now = value;
  endtask

  // Mostly well-formed sets and queries inside the count, with some noise and bad ranges.
  function automatic rsst_pkg::item_t random_item(int set_pct);
    rsst_pkg::item_t it;
    int              lim;
    int              first;
    int              last;
    lim = (count_now > 1024) ? 1024 : count_now;
    it.command       = 1'($urandom_range(0, 1));
    it.element_index = IW'($urandom);
    it.new_value     = $urandom;
    it.range_start   = IW'($urandom);
    it.range_end     = IW'($urandom);
    if (lim == 0 || $urandom_range(0, 9) == 0) return it;
    it.command       = ($urandom_range(0, 99) < set_pct) ? rsst_pkg::CMD_SET
                                                         : rsst_pkg::CMD_QUERY;
    it.element_index = IW'($urandom_range(0, lim - 1));
    case ($urandom_range(0, 7))
      0:       it.new_value = 32'h7fff_ffff;
      1:       it.new_value = 32'h8000_0000;
      2:       it.new_value = '1;
      3:       it.new_value = '0;
      default: it.new_value = $urandom;
    endcase
    first = $urandom_range(0, lim - 1);
    if ($urandom_range(0, 3) == 0) begin
      last = $urandom_range(first, lim - 1);
    end else begin
      last = $urandom_range(first, (first + 8 < lim) ? first + 8 : lim - 1);
    end
    it.range_start = IW'(first);
    it.range_end   = IW'(last);
    case ($urandom_range(0, 15))
      0: begin
        it.range_start = IW'(last);
        it.range_end   = IW'(first);
      end
      1: begin
        if (lim < 1024) begin
          it.range_end     = IW'(lim);
          it.element_index = IW'(lim);
        end
      end
      default: ;
    endcase
    return it;
  endfunction

  task automatic run_phase(int count, int items, int set_pct, bit calm);
    settle();
    set_count(count);
    steady = calm;
    repeat (items) send_item(random_item(set_pct));
  endtask

  initial begin
    int stall;
    rsp.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = idle_cycles();
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      @(posedge clk);
      while (!rsp.valid) @(posedge clk);
    end
  end

  initial begin
    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    req.valid         <= 1'b0;
    req.command       <= rsst_pkg::CMD_SET;
    req.element_index <= '0;
    req.new_value     <= '0;
    req.range_start   <= '0;
    req.range_end     <= '0;
    steady = 1'b0;
    count_now = int'(rsst_pkg::COUNT_RESET);
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    set_count(1024);
    send_set(0, 32'h7fff_ffff);
    send_set(1023, 32'h8000_0000);
    send_set(1, 32'hffff_ffff);
    send_set(512, 32'd5);
    send_query(0, 1023);
    send_query(0, 0);
    send_query(1023, 1023);
    send_query(1, 1022);
    send_query(5, 4);
    send_set(0, 32'h7fff_ffff);
    send_set(1, 32'd1);
    // The pair wraps past the largest positive value.
    send_query(0, 1);

    // Counts above the number of leaves behave as a full tree.
    settle();
    set_count(2047);
    send_query(0, 1023);
    send_set(1023, 32'h1234_5678);

    settle();
    set_count(1);
    send_set(1, 32'd9);
    send_set(0, 32'hffff_fff9);
    send_query(0, 0);
    send_query(0, 1);

    settle();
    set_count(0);
    send_set(0, 32'd1);
    send_query(0, 0);

    // Elements hidden by the smaller counts must come back unchanged.
    settle();
    set_count(1024);
    send_query(1023, 1023);
    send_query(0, 1023);

    run_phase(1024, 130, 70, 1'b0);
    run_phase(2047, 60, 40, 1'b1);
    run_phase(37, 80, 50, 1'b0);
    run_phase(1, 30, 50, 1'b0);
    run_phase(0, 20, 50, 1'b1);
    run_phase(700, 80, 40, 1'b0);
    run_phase(1024, 100, 50, 1'b0);

    steady = 1'b0;
    settle();
    repeat (32) @(posedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
